// ----- rtl/lrr_pkg.sv -----
// Shared constants, queue entry and state types for the range-limited LCG draw.
// No dependencies; every other file in rtl/ but lrr_if.sv imports this package.
package lrr_pkg;

	localparam logic [31:0] LcgMul  = 32'd214013;
	localparam logic [31:0] LcgAdd  = 32'd2531011;
	localparam int          PickBit = 16;
	localparam int          DrawLsb = 16;
	localparam int          DrawW   = 15;

	localparam int QueueDepth = 2;
	localparam int QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
	localparam int QCntW      = $clog2(QueueDepth + 1);
	localparam int DivCntW    = $clog2(DrawW);

	typedef enum logic [1:0] {
		KIND_PICK,
		KIND_DIRECT,
		KIND_DIVIDE
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [31:0]       base;
		logic [DrawW-1:0]  draw;
		logic [DrawW-1:0]  divisor;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_FIN
	} back_state_t;

endpackage

// ----- rtl/lrr_if.sv -----
// Valid/ready channel interfaces for requests and drawn values.
// No package dependencies.
interface lrr_req_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] lower_bound;
	logic signed [31:0] upper_bound;
	logic        [31:0] time_seed;

	modport source (output valid, lower_bound, upper_bound, time_seed, input ready);
	modport sink   (input valid, lower_bound, upper_bound, time_seed, output ready);
endinterface

interface lrr_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] random_value;

	modport source (output valid, random_value, input ready);
	modport sink   (input valid, random_value, output ready);
endinterface

// ----- rtl/lcg_random_in_range.sv -----
// A divided draw passes through the queue, the back end's 15-step restoring
// remainder loop (one quotient bit per cycle), the finish state and the result
// register; a draw whose span is zero or whose magnitude exceeds 15 bits skips the loop.
// The back end works on one draw at a time; the queue holds further classified draws.
// Reset (arst_n low, asynchronous): seed cleared and marked not loaded, queue
// emptied, back end idle, no result pending.
module lcg_random_in_range
	import lrr_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	lrr_req_if.sink   req,
	lrr_rsp_if.source rsp
);

	// Classified draws travel from front to back through a short queue, so the front
	// keeps taking requests while the result consumer stalls, until the queue is full.
	logic   push_valid;
	logic   push_ready;
	entry_t push_entry;
	logic   pop_valid;
	logic   pop_ready;
	entry_t pop_entry;

	// Front: seed on first transfer, advance the LCG, compute the span and
	// decide whether the draw needs the remainder unit.
	lrr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry)
	);

	// Queue: hold classified draws in order.
	lrr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_entry  (pop_entry)
	);

	// Back: reduce the 15-bit draw by the span magnitude, add the lower bound
	// and hold the result until the consumer takes the transfer.
	lrr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_entry (pop_entry),
		.rsp       (rsp)
	);

endmodule

// ----- rtl/lrr_front.sv -----
// Front end: accepts requests, advances the generator seed and classifies the draw.
// Depends on lrr_pkg and lrr_req_if.
module lrr_front
	import lrr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	lrr_req_if.sink    req,
	output logic       push_valid,
	input  logic       push_ready,
	output entry_t     push_entry
);

	logic [31:0] seed_q;
	logic        loaded_q;
	logic [31:0] seed_src;
	logic [31:0] seed_next;
	logic [31:0] span;
	logic [31:0] mag;
	logic        accept;

	assign accept    = req.valid && push_ready;
	assign seed_src  = loaded_q ? seed_q : req.time_seed;
	assign seed_next = seed_src * LcgMul + LcgAdd;
	assign span      = $unsigned(req.upper_bound) - $unsigned(req.lower_bound) + 32'd1;
	assign mag       = span[31] ? (32'd0 - span) : span;

	assign req.ready  = push_ready;
	assign push_valid = req.valid;

	always_comb begin
		push_entry.draw    = seed_next[DrawLsb +: DrawW];
		push_entry.divisor = mag[DrawW-1:0];
		push_entry.base    = $unsigned(req.lower_bound);
		if (span == 32'd0) begin
			push_entry.kind = KIND_PICK;
			push_entry.base = seed_next[PickBit] ? $unsigned(req.lower_bound)
				: $unsigned(req.upper_bound);
		end else if (mag[31:DrawW] != '0) begin
			// draw is always below the magnitude, so the remainder is the draw
			push_entry.kind = KIND_DIRECT;
		end else begin
			push_entry.kind = KIND_DIVIDE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q   <= '0;
			loaded_q <= 1'b0;
		end else if (accept) begin
			seed_q   <= seed_next;
			loaded_q <= 1'b1;
		end
	end

	a_stays_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		loaded_q |=> loaded_q)
		else $error("seed loaded flag dropped without reset");

endmodule

// ----- rtl/lrr_queue.sv -----
// Two-entry queue that decouples the front end from the divider back end.
// Depends on lrr_pkg.
module lrr_queue
	import lrr_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push_valid,
	output logic   push_ready,
	input  entry_t push_entry,
	output logic   pop_valid,
	input  logic   pop_ready,
	output entry_t pop_entry
);

	entry_t           mem_q [QueueDepth];
	logic [QPtrW-1:0] wr_ptr_q;
	logic [QPtrW-1:0] rd_ptr_q;
	logic [QCntW-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != QCntW'(QueueDepth));
	assign pop_valid  = (count_q != '0);
	assign pop_entry  = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCntW'(QueueDepth))
		else $error("queue occupancy above depth");

endmodule

// ----- rtl/lrr_back.sv -----
// Back end: restoring remainder, one bit per cycle, and the result register.
// Depends on lrr_pkg and lrr_rsp_if.
module lrr_back
	import lrr_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      pop_valid,
	output logic      pop_ready,
	input  entry_t    pop_entry,
	lrr_rsp_if.source rsp
);

	back_state_t        state_q, state_d;
	logic [31:0]        base_q;
	logic [DrawW-1:0]   draw_q;
	logic [DrawW-1:0]   div_q;
	logic [DrawW-1:0]   rem_q;
	logic [DivCntW-1:0] cnt_q;
	logic [31:0]        res_q, res_d;
	logic               out_valid_q;
	logic [31:0]        out_value_q;

	logic               out_free;
	logic               load_entry;
	logic               step_div;
	logic               set_res;
	logic               load_out;
	logic [DrawW:0]     trial;
	logic               ge;
	logic [DrawW-1:0]   rem_next;

	assign out_free = !out_valid_q || rsp.ready;
	assign trial    = {rem_q, draw_q[DrawW-1]};
	assign ge       = trial >= {1'b0, div_q};
	assign rem_next = ge ? DrawW'(trial - {1'b0, div_q}) : trial[DrawW-1:0];

	always_comb begin
		state_d    = state_q;
		pop_ready  = 1'b0;
		load_entry = 1'b0;
		step_div   = 1'b0;
		set_res    = 1'b0;
		load_out   = 1'b0;
		res_d      = res_q;
		unique case (state_q)
			ST_IDLE: begin
				pop_ready = 1'b1;
				if (pop_valid) begin
					unique case (pop_entry.kind)
						KIND_DIRECT: begin
							set_res = 1'b1;
							res_d   = pop_entry.base + {{(32-DrawW){1'b0}}, pop_entry.draw};
							state_d = ST_FIN;
						end
						KIND_DIVIDE: begin
							load_entry = 1'b1;
							state_d    = ST_DIV;
						end
						default: begin
							set_res = 1'b1;
							res_d   = pop_entry.base;
							state_d = ST_FIN;
						end
					endcase
				end
			end
			ST_DIV: begin
				step_div = 1'b1;
				if (cnt_q == '0) begin
					set_res = 1'b1;
					res_d   = base_q + {{(32-DrawW){1'b0}}, rem_next};
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_entry) begin
				cnt_q <= DivCntW'(DrawW - 1);
			end else if (step_div) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_entry) begin
			base_q <= pop_entry.base;
			draw_q <= pop_entry.draw;
			div_q  <= pop_entry.divisor;
			rem_q  <= '0;
		end else if (step_div) begin
			draw_q <= {draw_q[DrawW-2:0], 1'b0};
			rem_q  <= rem_next;
		end
		if (set_res) begin
			res_q <= res_d;
		end
		if (load_out) begin
			out_value_q <= res_q;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.random_value = $signed(out_value_q);

	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && cnt_q == '0) |-> (rem_next < div_q))
		else $error("remainder not below divisor at end of division");

	a_fin_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && !out_free) |=> (state_q == ST_FIN))
		else $error("result left finish state while output register was full");

endmodule

// ----- tb/lrr_draw_checker.sv -----
// Watches the request and result channels of the range-limited LCG draw,
// predicts each drawn value and compares it with the block. Uses lrr_pkg and lrr_if.
module lrr_draw_checker
	import lrr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	lrr_req_if   req,
	lrr_rsp_if   rsp,
	output int   fail_count,
	output int   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [31:0] seed_q;
	logic        seeded_q;
	logic [31:0] predicted_draws[$];

	function automatic logic [31:0] advance_lcg(input logic [31:0] s);
		return s * LcgMul + LcgAdd;
	endfunction

	// Pick lo or hi on a wrapped-to-zero span, else lo + r mod |span|.
	function automatic logic [31:0] pick_in_range(input logic [31:0] lo, input logic [31:0] hi,
			input logic [31:0] s);
		logic [31:0] span;
		logic [31:0] mag;
		logic [31:0] r;
		span = hi - lo + 32'd1;
		if (span == 32'd0)
			return s[PickBit] ? lo : hi;
		r = {{(32-DrawW){1'b0}}, s[DrawLsb +: DrawW]};
		mag = span[31] ? (32'd0 - span) : span;
		return lo + (r % mag);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [31:0] s;
		logic [31:0] want;
		if (!arst_n) begin
			seed_q <= '0;
			seeded_q <= 1'b0;
			predicted_draws.delete();
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (req.valid && req.ready) begin
				s = advance_lcg(seeded_q ? seed_q : req.time_seed);
				seed_q <= s;
				seeded_q <= 1'b1;
				predicted_draws.push_back(pick_in_range(req.lower_bound, req.upper_bound, s));
			end
			if (rsp.valid && rsp.ready) begin
				if (predicted_draws.size() == 0) begin
					$error("random_value: none expected, actual %0d", rsp.random_value);
					fail_count <= fail_count + 1;
				end else begin
					want = predicted_draws.pop_front();
					if (rsp.random_value !== want) begin
						$error("random_value: expected %0d, actual %0d",
							$signed(want), rsp.random_value);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending <= predicted_draws.size();
		end
	end

endmodule

// ----- tb/lcg_random_in_range_test.sv -----
// Top of the range-limited LCG draw testbench: clock, reset, request and result
// traffic, and the verdict. Uses lrr_pkg, lrr_if, lrr_draw_checker and the block.
module lcg_random_in_range_test;
	timeunit 1ns;
	timeprecision 1ps;

	import lrr_pkg::*;

	localparam int RandomItems = 1000;
	localparam int CycleLimit  = 600000;
	localparam int DrainCycles = 40;
	localparam int HoldCycles  = 400;
	localparam int HoldAfter   = 40;

	// Traffic phases: slow receiver, slow sender, then full rate on both sides.
	typedef enum logic [1:0] {
		PH_SLOW_SINK,
		PH_SLOW_SOURCE,
		PH_FULL_RATE
	} traffic_phase_t;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   items_sent;
	traffic_phase_t phase;

	lrr_req_if req ();
	lrr_rsp_if rsp ();

	lcg_random_in_range uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	lrr_draw_checker draw_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Idle percentage of each side for the current phase.
	function automatic int source_idle_pct(input traffic_phase_t ph);
		case (ph)
			PH_SLOW_SINK:   return 12;
			PH_SLOW_SOURCE: return 54;
			default:        return 0;
		endcase
	endfunction

	function automatic int sink_idle_pct(input traffic_phase_t ph);
		case (ph)
			PH_SLOW_SINK:   return 54;
			PH_SLOW_SOURCE: return 12;
			default:        return 0;
		endcase
	endfunction

	// Offer one request, with random idle cycles ahead of it, and hold it until the
	// transfer. Returns at the falling edge after the transfer.
	task automatic send_request(input logic [31:0] lo, input logic [31:0] hi,
			input logic [31:0] ts);
		while ($urandom_range(99) < source_idle_pct(phase)) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid       <= 1'b1;
		req.lower_bound <= lo;
		req.upper_bound <= hi;
		req.time_seed   <= ts;
		do
			@(posedge clk);
		while (!req.ready);
		items_sent++;
		@(negedge clk);
	endtask

	// Random request shaped mostly toward spans the divider has to work on; the rest
	// covers wrapped-to-zero spans, crossed bounds, single values and wide spans.
	task automatic send_random_request();
		logic [31:0] lo;
		logic [31:0] hi;
		int          pick;
		lo = $urandom;
		pick = $urandom_range(99);
		if (pick < 40)
			hi = lo + $urandom_range(0, 300);
		else if (pick < 55)
			hi = lo + 32'h7ff0 + $urandom_range(0, 32);
		else if (pick < 65)
			hi = lo - 32'd1;
		else if (pick < 80)
			hi = $urandom;
		else if (pick < 90)
			hi = lo - $urandom_range(2, 40000);
		else
			hi = lo;
		send_request(lo, hi, $urandom);
	endtask

	// Reset once, then directed requests, then random traffic in three phases.
	initial begin
		arst_n          = 1'b0;
		req.valid       = 1'b0;
		req.lower_bound = '0;
		req.upper_bound = '0;
		req.time_seed   = '0;
		phase           = PH_SLOW_SINK;
		items_sent      = 0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// First request seeds from the clock value; the next one must ignore it.
		send_request(32'd0, 32'd9, 32'hffff_ffff);
		send_request(32'd0, 32'd9, 32'h0000_0000);
		// Full 32-bit range wraps the span to zero: lo or hi by the pick bit.
		repeat (4) send_request(32'h8000_0000, 32'h7fff_ffff, $urandom);
		send_request(32'd5, 32'd4, $urandom);
		// Single-value ranges at the extremes.
		send_request(32'h8000_0000, 32'h8000_0000, $urandom);
		send_request(32'h7fff_ffff, 32'h7fff_ffff, $urandom);
		send_request(32'd0, 32'd0, $urandom);
		send_request(32'hffff_ffff, 32'hffff_ffff, $urandom);
		// Span of -2^31 read as signed: magnitude 2^31.
		send_request(32'd0, 32'h7fff_ffff, $urandom);
		// Crossed bounds give a negative span.
		send_request(32'd10, 32'd5, $urandom);
		send_request(32'd100, 32'hffff_ff9c, $urandom);
		// Sum of lo and remainder wraps past the top.
		send_request(32'h7fff_fff0, 32'h8000_000f, $urandom);
		// Spans around the 15-bit draw width.
		send_request(32'd0, 32'h0000_7ffe, $urandom);
		send_request(32'd0, 32'h0000_7fff, $urandom);
		send_request(32'd0, 32'h0000_ffff, $urandom);
		send_request(32'hffff_ffff, 32'd0, $urandom);
		send_request(32'hffff_fc18, 32'h7fff_ffff, $urandom);

		for (int i = 0; i < RandomItems; i++) begin
			if (i == RandomItems / 3)
				phase = PH_SLOW_SOURCE;
			else if (i == 2 * RandomItems / 3)
				phase = PH_FULL_RATE;
			send_random_request();
		end
		req.valid <= 1'b0;

		// Drain: wait for every predicted draw, then a margin for stray results.
		while (pending != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Receiver: random stalls by phase, plus one long hold-off once traffic is
	// under way so the queue fills and the request side stalls.
	initial begin
		int  hold_left;
		bit  held;
		hold_left = 0;
		held = 1'b0;
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				rsp.ready <= 1'b0;
			end else if (!held && items_sent >= HoldAfter) begin
				held = 1'b1;
				hold_left = HoldCycles;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= arst_n && ($urandom_range(99) >= sink_idle_pct(phase));
			end
		end
	end

	// Watchdog: end the run if traffic stops making progress.
	initial begin
		repeat (CycleLimit) @(posedge clk);
		$display("FAILURE");
		$finish;
	end

endmodule

// ----- lcg_random_in_range.f -----
rtl/lrr_pkg.sv
rtl/lrr_if.sv
rtl/lrr_front.sv
rtl/lrr_queue.sv
rtl/lrr_back.sv
rtl/lcg_random_in_range.sv
tb/lrr_draw_checker.sv
tb/lcg_random_in_range_test.sv
